// ----- hdl/spd_pkg.sv -----
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the sensor packet deframer
// word types of both channels, status codes, register map, header layout
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;

    // header layout, byte positions in the buffer
    localparam int IDX_TAG_HI   = 0;
    localparam int IDX_TAG_LO   = 1;
    localparam int IDX_ADDR_LST = 5;
    localparam int IDX_TYPE     = 6;
    localparam int IDX_LEN_HI   = 7;
    localparam int IDX_LEN_LO   = 8;
    localparam int HEADER_BYTES = 9;
    localparam int MIN_BUFFER   = 11;
    localparam int CSUM_BYTES   = 2;

    // register map
    localparam int APB_AW = 3;
    localparam logic REG_EXP_ADDR  = 1'b0;
    localparam logic REG_FRAME_TAG = 1'b1;
    localparam logic [31:0] EXP_ADDR_RST  = 32'hFFFF_FFFF;
    localparam logic [15:0] FRAME_TAG_RST = 16'hEF01;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT_BUF = 2'd1,
        ST_REJECT    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic [8:0] payload_length;
        logic [1:0] status;
        logic [8:0] frame_bytes;
    } t_out_word;

endpackage

`default_nettype wire

// ----- hdl/sensor_packet_deframer_top.sv -----
// ----------------------------------------------------------------------------
// sensor_packet_deframer_top: byte-stream frame deframer
// Bytes of a receive buffer enter on the input channel (valid/ready), one word
// per byte, with buffer_end set on the last byte. Payload bytes of a frame
// with a good header leave on the output channel as they arrive; each buffer
// gives exactly one status word (ok, short buffer, rejected frame). The status
// is decided at byte 11, at the checksum, or at the buffer end, whichever rule
// of the frame check applies first; later bytes of that buffer give nothing.
// A result word is loaded into the output register once its byte has passed
// through the input register and the output register is free or being read.
// Throughput: one byte per cycle while the receiver takes the output words,
// set by the combinational parse step between the two registers.
// A stalled receiver holds the output word; the input register still takes
// one more byte, and o_in_ready drops only when both registers are full.
// Reset (synchronous, active low) empties both registers, clears the parse
// state and loads device address 0xFFFFFFFF and frame_tag 0xEF01.
// Registers on the APB port: device address at 0x0, frame_tag at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_packet_deframer_top #(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire spd_pkg::t_in_word          i_in_word,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output spd_pkg::t_out_word              o_out_word,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [spd_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import spd_pkg::*;

    logic [31:0] r_dev_address;
    logic [15:0] r_frame_tag;
    logic        r_in_valid;
    t_in_word    r_in_word;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        proc_fire;
    logic        cfg_wr;
    logic        res_valid;
    t_out_word   res_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FRAME_TAG) ? {16'h0000, r_frame_tag}
                                                : r_dev_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_address <= EXP_ADDR_RST;
            r_frame_tag   <= FRAME_TAG_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_TAG) begin
                r_frame_tag <= pwdata[15:0];
            end else begin
                r_dev_address <= pwdata;
            end
        end
    end

    // parse a byte once its result has somewhere to go
    assign proc_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    spd_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (proc_fire),
        .i_word        (r_in_word),
        .i_dev_address (r_dev_address),
        .i_frame_tag   (r_frame_tag),
        .o_res_valid   (res_valid),
        .o_res_word    (res_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ----- hdl/spd_parse.sv -----
// ----------------------------------------------------------------------------
// spd_parse: frame parser state and per-byte decision logic
// holds the per-buffer parse state and turns one byte into at most one word
// ----------------------------------------------------------------------------
`default_nettype none

module spd_parse #(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire spd_pkg::t_in_word i_word,
    input  wire logic [31:0]       i_dev_address,
    input  wire logic [15:0]       i_frame_tag,
    output logic                   o_res_valid,
    output spd_pkg::t_out_word     o_res_word
);
    import spd_pkg::*;

    // index must hold the count one past the last checksum byte
    localparam int IW = $clog2(MAX_PAYLOAD + MIN_BUFFER + 1);
    localparam logic [16:0] LEN_MAX = 17'(MAX_PAYLOAD + CSUM_BYTES);

    logic [IW-1:0] r_byte_index, n_byte_index;
    logic [7:0]    r_tag_high, n_tag_high;
    logic [31:0]   r_address_shift, n_address_shift;
    logic [7:0]    r_type_reg, n_type_reg;
    logic [15:0]   r_length_field, n_length_field;
    logic [15:0]   r_running_sum, n_running_sum;
    logic [7:0]    r_checksum_high, n_checksum_high;
    logic          r_pending_error, n_pending_error;
    logic          r_status_sent, n_status_sent;

    logic [7:0]  rx_b;
    logic        last;
    logic [31:0] addr_next;
    logic [15:0] len_next;
    logic [16:0] idx_ext;
    logic [16:0] len_ext;
    logic        payload_out;
    logic        check_done;
    logic        check_ok;
    logic        res_valid;
    t_out_word   res_word;

    assign rx_b      = i_word.rx_byte;
    assign last      = i_word.buffer_end;
    assign addr_next = {r_address_shift[23:0], rx_b};
    assign len_next  = {r_length_field[15:8], rx_b};
    assign idx_ext   = 17'(r_byte_index);
    assign len_ext   = {1'b0, r_length_field};

    always_comb begin
        n_byte_index    = r_byte_index;
        n_tag_high      = r_tag_high;
        n_address_shift = r_address_shift;
        n_type_reg      = r_type_reg;
        n_length_field  = r_length_field;
        n_running_sum   = r_running_sum;
        n_checksum_high = r_checksum_high;
        n_pending_error = r_pending_error;
        n_status_sent   = r_status_sent;
        payload_out     = 1'b0;
        check_done      = 1'b0;
        check_ok        = 1'b0;
        res_valid       = 1'b0;
        res_word        = '0;

        if (!r_status_sent) begin
            if (r_byte_index == IW'(IDX_TAG_HI)) begin
                n_tag_high = rx_b;
            end else if (r_byte_index == IW'(IDX_TAG_LO)) begin
                if ({r_tag_high, rx_b} != i_frame_tag) begin
                    n_pending_error = 1'b1;
                end
            end else if (r_byte_index <= IW'(IDX_ADDR_LST)) begin
                n_address_shift = addr_next;
                if (r_byte_index == IW'(IDX_ADDR_LST) && addr_next != i_dev_address) begin
                    n_pending_error = 1'b1;
                end
            end else if (r_byte_index == IW'(IDX_TYPE)) begin
                n_type_reg    = rx_b;
                n_running_sum = {8'h00, rx_b};
            end else if (r_byte_index == IW'(IDX_LEN_HI)) begin
                n_length_field = {rx_b, 8'h00};
                n_running_sum  = r_running_sum + {8'h00, rx_b};
            end else if (r_byte_index == IW'(IDX_LEN_LO)) begin
                n_length_field = len_next;
                n_running_sum  = r_running_sum + {8'h00, rx_b};
                if (len_next < 16'(CSUM_BYTES) || {1'b0, len_next} > LEN_MAX) begin
                    n_pending_error = 1'b1;
                end
            end else if (!r_pending_error) begin
                // payload ends at index length + 6, checksum follows
                if (idx_ext < len_ext + 17'(HEADER_BYTES - CSUM_BYTES)) begin
                    n_running_sum = r_running_sum + {8'h00, rx_b};
                    payload_out   = 1'b1;
                end else if (idx_ext == len_ext + 17'(HEADER_BYTES - CSUM_BYTES)) begin
                    n_checksum_high = rx_b;
                end else if (idx_ext == len_ext + 17'(HEADER_BYTES - 1)) begin
                    check_done = 1'b1;
                    check_ok   = ({r_checksum_high, rx_b} == r_running_sum);
                end
            end

            n_byte_index = r_byte_index + 1'b1;

            if (last) begin
                res_valid     = 1'b1;
                res_word.kind = KIND_STATUS;
                if (n_byte_index < IW'(MIN_BUFFER)) begin
                    res_word.status = ST_SHORT_BUF;
                end else if (check_done && check_ok) begin
                    res_word.status = ST_OK;
                end else begin
                    res_word.status = ST_REJECT;
                end
            end else if (check_done) begin
                res_valid       = 1'b1;
                res_word.kind   = KIND_STATUS;
                res_word.status = check_ok ? ST_OK : ST_REJECT;
                n_status_sent   = 1'b1;
            end else if (n_pending_error && n_byte_index >= IW'(MIN_BUFFER)) begin
                res_valid       = 1'b1;
                res_word.kind   = KIND_STATUS;
                res_word.status = ST_REJECT;
                n_status_sent   = 1'b1;
            end else if (payload_out) begin
                res_valid             = 1'b1;
                res_word.kind         = KIND_PAYLOAD;
                res_word.payload_byte = rx_b;
            end

            // frame details only go out with a good checksum
            if (check_done && check_ok && n_byte_index >= IW'(MIN_BUFFER)) begin
                res_word.packet_type    = r_type_reg;
                res_word.payload_length = 9'(r_length_field - 16'(CSUM_BYTES));
                res_word.frame_bytes    = 9'(r_length_field + 16'(HEADER_BYTES));
            end
        end

        if (last) begin
            n_byte_index    = '0;
            n_tag_high      = '0;
            n_address_shift = '0;
            n_type_reg      = '0;
            n_length_field  = '0;
            n_running_sum   = '0;
            n_checksum_high = '0;
            n_pending_error = 1'b0;
            n_status_sent   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index    <= '0;
            r_tag_high      <= '0;
            r_address_shift <= '0;
            r_type_reg      <= '0;
            r_length_field  <= '0;
            r_running_sum   <= '0;
            r_checksum_high <= '0;
            r_pending_error <= 1'b0;
            r_status_sent   <= 1'b0;
        end else if (i_fire) begin
            r_byte_index    <= n_byte_index;
            r_tag_high      <= n_tag_high;
            r_address_shift <= n_address_shift;
            r_type_reg      <= n_type_reg;
            r_length_field  <= n_length_field;
            r_running_sum   <= n_running_sum;
            r_checksum_high <= n_checksum_high;
            r_pending_error <= n_pending_error;
            r_status_sent   <= n_status_sent;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res_word  = res_word;

endmodule

`default_nettype wire

// ----- hdl/spd_checker.sv -----
// ----------------------------------------------------------------------------
// spd_checker: port-level checks of the deframer
// watches the output channel for held words and consistent status words
// ----------------------------------------------------------------------------
`default_nettype none

module spd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire spd_pkg::t_out_word o_out_word
);
    import spd_pkg::*;

    // a stalled word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // ok status: frame bytes are header plus length, payload is length less checksum
    a_ok_sizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == KIND_STATUS && o_out_word.status == ST_OK
        |-> o_out_word.frame_bytes == 9'(o_out_word.payload_length + 9'd11))
        else $error("ok status with inconsistent sizes");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.kind == KIND_STATUS) ||
                        (o_out_word.status == ST_OK && o_out_word.frame_bytes == 9'd0))
        else $error("payload word carries status fields");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == KIND_STATUS && o_out_word.status != ST_OK
        |-> o_out_word.payload_length == 9'd0 && o_out_word.packet_type == 8'd0 &&
            o_out_word.status != 2'd3)
        else $error("failed status carries frame details");

endmodule

bind sensor_packet_deframer_top spd_checker u_spd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire

// ----- bench/tb_sensor_packet_deframer_top.sv -----
// ----------------------------------------------------------------------------
// tb_sensor_packet_deframer_top: self-checking bench of the packet deframer
// Receive buffers go in one byte word at a time. A built-in deframer model
// predicts every payload and status word, and each output word is compared
// field by field in arrival order. Directed buffers cover good frames of
// every size class, short buffers, header faults, checksum faults, truncation
// and trailing bytes. Random buffers follow under three idling mixes and
// several register settings, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sensor_packet_deframer_top;
    import spd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BYTES  = 96;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAXP          = MAX_PAYLOAD_DEF;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_word            i_in_word   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_word           o_out_word;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    // deframer model: registers and per-buffer parse state
    logic [31:0] want_addr;
    logic [15:0] want_tag;
    int unsigned pos;
    logic [7:0]  tag_hi;
    logic [31:0] addr_acc;
    logic [7:0]  ptype;
    logic [15:0] len_field;
    logic [15:0] csum_acc;
    logic [7:0]  csum_hi;
    bit          hdr_bad;
    bit          status_done;

    t_out_word   deframed_q[$];
    logic [7:0]  frame_q[$];
    t_out_word   want_w;

    int fail_count    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 83;
    int hold_len      = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    always #CLK_HALF i_clk = ~i_clk;

    sensor_packet_deframer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    task automatic clear_frame_state;
        pos         = 0;
        tag_hi      = '0;
        addr_acc    = '0;
        ptype       = '0;
        len_field   = '0;
        csum_acc    = '0;
        csum_hi     = '0;
        hdr_bad     = 1'b0;
        status_done = 1'b0;
    endtask

    function automatic t_out_word status_word(input t_status st, input bit good);
        t_out_word w;
        w        = '0;
        w.kind   = KIND_STATUS;
        w.status = st;
        if (good) begin
            w.packet_type    = ptype;
            w.payload_length = 9'(len_field - 16'd2);
            w.frame_bytes    = 9'(len_field + 16'd9);
        end
        return w;
    endfunction

    // advances the parse by one accepted byte and queues the word it yields
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        int unsigned cnt;
        int unsigned plen;
        int unsigned k;
        bit          stream_it;
        bit          csum_seen;
        bit          csum_good;
        t_out_word   w;
        stream_it = 1'b0;
        csum_seen = 1'b0;
        csum_good = 1'b0;
        if (status_done) begin
            if (last) clear_frame_state();
            return;
        end
        if (pos == IDX_TAG_HI) begin
            tag_hi = b;
        end else if (pos == IDX_TAG_LO) begin
            if ({tag_hi, b} != want_tag) hdr_bad = 1'b1;
        end else if (pos <= IDX_ADDR_LST) begin
            addr_acc = {addr_acc[23:0], b};
            if (pos == IDX_ADDR_LST && addr_acc != want_addr) hdr_bad = 1'b1;
        end else if (pos == IDX_TYPE) begin
            ptype    = b;
            csum_acc = {8'h00, b};
        end else if (pos == IDX_LEN_HI) begin
            len_field = {b, 8'h00};
            csum_acc  = csum_acc + {8'h00, b};
        end else if (pos == IDX_LEN_LO) begin
            len_field[7:0] = b;
            csum_acc       = csum_acc + {8'h00, b};
            if (len_field < 16'd2 || 32'(len_field) - 2 > MAXP) hdr_bad = 1'b1;
        end else if (!hdr_bad) begin
            plen = 32'(len_field) - 2;
            k    = pos - HEADER_BYTES;
            if (k < plen) begin
                csum_acc  = csum_acc + {8'h00, b};
                stream_it = 1'b1;
            end else if (k == plen) begin
                csum_hi = b;
            end else if (k == plen + 1) begin
                csum_seen = 1'b1;
                csum_good = ({csum_hi, b} == csum_acc);
            end
        end
        cnt = pos + 1;
        pos = cnt;
        if (last) begin
            if (cnt < MIN_BUFFER)
                deframed_q.push_back(status_word(ST_SHORT_BUF, 1'b0));
            else if (csum_seen)
                deframed_q.push_back(status_word(csum_good ? ST_OK : ST_REJECT,
                                                 csum_good));
            else
                deframed_q.push_back(status_word(ST_REJECT, 1'b0));
            clear_frame_state();
            return;
        end
        if (csum_seen) begin
            deframed_q.push_back(status_word(csum_good ? ST_OK : ST_REJECT, csum_good));
            status_done = 1'b1;
        end else if (hdr_bad && cnt >= MIN_BUFFER) begin
            deframed_q.push_back(status_word(ST_REJECT, 1'b0));
            status_done = 1'b1;
        end else if (stream_it) begin
            w              = '0;
            w.kind         = KIND_PAYLOAD;
            w.payload_byte = b;
            deframed_q.push_back(w);
        end
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= hold_len;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (deframed_q.size() == 0) begin
                $error("output word %h with nothing pending", o_out_word);
                fail_count++;
            end else begin
                want_w = deframed_q.pop_front();
                check_field("kind", want_w.kind, o_out_word.kind);
                check_field("payload_byte", want_w.payload_byte, o_out_word.payload_byte);
                check_field("packet_type", want_w.packet_type, o_out_word.packet_type);
                check_field("payload_length", want_w.payload_length,
                            o_out_word.payload_length);
                check_field("status", want_w.status, o_out_word.status);
                check_field("frame_bytes", want_w.frame_bytes, o_out_word.frame_bytes);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{rx_byte: b, buffer_end: last};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        deframe_byte(b, last);
    endtask

    task automatic send_buffer;
        for (int n = 0; n < frame_q.size(); n++)
            send_byte(frame_q[n], n == frame_q.size() - 1);
    endtask

    // header, payload of random bytes, checksum xor-ed with csum_flip
    task automatic make_frame(input logic [15:0] tag, input logic [31:0] addr,
                              input logic [7:0] ptype_b, input logic [15:0] lenf,
                              input int npay, input logic [15:0] csum_flip);
        logic [15:0] sum;
        logic [7:0]  b;
        frame_q.delete();
        frame_q.push_back(tag[15:8]);
        frame_q.push_back(tag[7:0]);
        frame_q.push_back(addr[31:24]);
        frame_q.push_back(addr[23:16]);
        frame_q.push_back(addr[15:8]);
        frame_q.push_back(addr[7:0]);
        frame_q.push_back(ptype_b);
        frame_q.push_back(lenf[15:8]);
        frame_q.push_back(lenf[7:0]);
        sum = {8'h00, ptype_b} + {8'h00, lenf[15:8]} + {8'h00, lenf[7:0]};
        for (int n = 0; n < npay; n++) begin
            b = 8'($urandom);
            frame_q.push_back(b);
            sum = sum + {8'h00, b};
        end
        sum = sum ^ csum_flip;
        frame_q.push_back(sum[15:8]);
        frame_q.push_back(sum[7:0]);
    endtask

    task automatic good_frame(input logic [7:0] ptype_b, input int npay);
        make_frame(want_tag, want_addr, ptype_b, 16'(npay + 2), npay, 16'h0000);
    endtask

    task automatic cut_frame(input int keep);
        while (frame_q.size() > keep) frame_q.delete(frame_q.size() - 1);
    endtask

    task automatic add_trailing(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (reg_sel == REG_EXP_ADDR)
            want_addr = value;
        else
            want_tag = value[15:0];
    endtask

    task automatic test_good_frames;
        good_frame(8'h00, 0);
        send_buffer();
        good_frame(8'hFF, 3);
        send_buffer();
        good_frame(8'h5A, MAXP);
        send_buffer();
    endtask

    task automatic test_short_buffers;
        good_frame(8'h11, 0);
        cut_frame(MIN_BUFFER - 1);
        send_buffer();
        good_frame(8'h22, 0);
        cut_frame(1);
        send_buffer();
        // header fault does not matter when the buffer ends early
        make_frame(~want_tag, want_addr, 8'h33, 16'd4, 2, 16'h0000);
        cut_frame(5);
        send_buffer();
    endtask

    task automatic test_header_faults;
        make_frame(want_tag ^ 16'h0100, want_addr, 8'h44, 16'd6, 4, 16'h0000);
        add_trailing(2);
        send_buffer();
        make_frame(want_tag, want_addr ^ 32'h8000_0000, 8'h45, 16'd6, 4, 16'h0000);
        send_buffer();
        // bad tag with the buffer ending exactly at the status byte
        make_frame(want_tag ^ 16'h0001, want_addr, 8'h46, 16'd2, 0, 16'h0000);
        cut_frame(MIN_BUFFER);
        send_buffer();
    endtask

    task automatic test_length_range;
        make_frame(want_tag, want_addr, 8'h50, 16'd0, 2, 16'h0000);
        send_buffer();
        make_frame(want_tag, want_addr, 8'h51, 16'd1, 2, 16'h0000);
        send_buffer();
        make_frame(want_tag, want_addr, 8'h52, 16'(MAXP + 3), 2, 16'h0000);
        send_buffer();
        make_frame(want_tag, want_addr, 8'h53, 16'hFFFF, 2, 16'h0000);
        send_buffer();
    endtask

    task automatic test_checksum_and_truncation;
        make_frame(want_tag, want_addr, 8'h60, 16'd6, 4, 16'h8000);
        send_buffer();
        make_frame(want_tag, want_addr, 8'h61, 16'd3, 1, 16'h0001);
        send_buffer();
        // end on the first checksum byte
        good_frame(8'h62, 4);
        cut_frame(frame_q.size() - 1);
        send_buffer();
        // end in the middle of the payload, that byte is not streamed
        good_frame(8'h63, 5);
        cut_frame(HEADER_BYTES + 3);
        send_buffer();
    endtask

    task automatic test_trailing_bytes;
        good_frame(8'h70, 2);
        add_trailing(3);
        send_buffer();
    endtask

    task automatic test_register_extremes;
        wait_drained();
        reg_write(REG_EXP_ADDR, 32'h0000_0000);
        reg_write(REG_FRAME_TAG, 32'h0000_0000);
        good_frame(8'h80, 3);
        send_buffer();
        make_frame(16'hEF01, 32'hFFFF_FFFF, 8'h81, 16'd4, 2, 16'h0000);
        send_buffer();
        wait_drained();
        reg_write(REG_EXP_ADDR, 32'hFFFF_FFFF);
        reg_write(REG_FRAME_TAG, 32'h0000_FFFF);
        good_frame(8'h82, 2);
        send_buffer();
        make_frame(16'hEF01, want_addr, 8'h83, 16'd4, 2, 16'h0000);
        send_buffer();
    endtask

    task automatic test_backpressure;
        wait_drained();
        hold_len <= HOLD_CYCLES;
        hold_seq <= hold_seq + 1;
        good_frame(8'h90, 20);
        send_buffer();
    endtask

    task automatic random_buffer;
        int          pick;
        int          npay;
        int          extra;
        logic [15:0] lenf;
        pick  = $urandom_range(99);
        npay  = ($urandom_range(15) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        extra = ($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0;
        if (pick < 60) begin
            good_frame(8'($urandom), npay);
        end else if (pick < 68) begin
            make_frame(want_tag, want_addr, 8'($urandom), 16'(npay + 2), npay,
                       16'(1 << $urandom_range(15)));
        end else if (pick < 74) begin
            make_frame(want_tag ^ 16'(1 << $urandom_range(15)), want_addr,
                       8'($urandom), 16'(npay + 2), npay, 16'h0000);
        end else if (pick < 80) begin
            make_frame(want_tag, want_addr ^ (32'h1 << $urandom_range(31)),
                       8'($urandom), 16'(npay + 2), npay, 16'h0000);
        end else if (pick < 86) begin
            case ($urandom_range(3))
                0: lenf = 16'd0;
                1: lenf = 16'd1;
                2: lenf = 16'(MAXP + 3);
                default: lenf = 16'($urandom_range(MAXP + 3, 16'hFFFF));
            endcase
            make_frame(want_tag, want_addr, 8'($urandom), lenf, $urandom_range(0, 4),
                       16'h0000);
        end else if (pick < 93) begin
            good_frame(8'($urandom), npay);
            cut_frame($urandom_range(1, frame_q.size() - 1));
            extra = 0;
        end else begin
            frame_q.delete();
            add_trailing($urandom_range(1, 20));
            extra = 0;
        end
        add_trailing(extra);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_bytes);
        int sent;
        wait_drained();
        send_idle_pct  = send_pct;
        recv_idle_pct <= recv_pct;
        reg_write(REG_EXP_ADDR, $urandom);
        reg_write(REG_FRAME_TAG, $urandom);
        sent = 0;
        while (sent < n_bytes) begin
            random_buffer();
            sent += frame_q.size();
            send_buffer();
        end
    endtask

    initial begin
        want_addr = EXP_ADDR_RST;
        want_tag  = FRAME_TAG_RST;
        clear_frame_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_good_frames();
        test_short_buffers();
        test_header_faults();
        test_length_range();
        test_checksum_and_truncation();
        test_trailing_bytes();
        test_register_extremes();
        test_random_traffic(7, 83, RANDOM_BYTES / 3);
        test_random_traffic(83, 7, RANDOM_BYTES / 3);
        test_random_traffic(0, 0, RANDOM_BYTES / 3);
        test_backpressure();

        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
